>>> rtl/core/hrhp_pkg.sv
`default_nettype none
package hrhp_pkg;

    // Depth of the queue between the byte classifier and the parse engine.
    localparam int QueueDepth = 4;
    localparam int QueueAw    = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    // Status codes of a result item.
    localparam logic [1:0] StMore = 2'd0;
    localparam logic [1:0] StDone = 2'd1;
    localparam logic [1:0] StBad  = 2'd2;

    // Field tags of a result item.
    localparam logic [2:0] TagNone   = 3'd0;
    localparam logic [2:0] TagMethod = 3'd1;
    localparam logic [2:0] TagUri    = 3'd2;
    localparam logic [2:0] TagName   = 3'd3;
    localparam logic [2:0] TagValue  = 3'd4;

    // Largest value of a version counter.
    localparam logic [7:0] VersionMax = 8'd255;

    // Parser phases, numbered in the order the request head is walked.
    typedef enum logic [4:0] {
        PH_METHOD_START = 5'd0,
        PH_METHOD       = 5'd1,
        PH_URI_START    = 5'd2,
        PH_URI          = 5'd3,
        PH_H            = 5'd4,
        PH_T1           = 5'd5,
        PH_T2           = 5'd6,
        PH_P            = 5'd7,
        PH_SLASH        = 5'd8,
        PH_MAJ_START    = 5'd9,
        PH_MAJ          = 5'd10,
        PH_MIN_START    = 5'd11,
        PH_MIN          = 5'd12,
        PH_LF1          = 5'd13,
        PH_LINE_START   = 5'd14,
        PH_LWS          = 5'd15,
        PH_NAME         = 5'd16,
        PH_SP_VALUE     = 5'd17,
        PH_VALUE        = 5'd18,
        PH_LF2          = 5'd19,
        PH_LF3          = 5'd20
    } t_phase;

    // One input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [1:0] status;
        logic [2:0] field_tag;
        logic [7:0] token_byte;
        logic       new_header;
        logic [7:0] version_major;
        logic [7:0] version_minor;
        logic [4:0] phase;
    } t_out_item;

    // A byte together with its character classes, as the engine sees it.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
        logic       is_token;
        logic       is_ctl;
        logic       is_dec;
        logic       is_space;
        logic       is_tab;
        logic       is_cr;
        logic       is_lf;
        logic       is_colon;
        logic       is_dot;
        logic       is_slash;
        logic       is_h;
        logic       is_t;
        logic       is_p;
    } t_byte_class;

endpackage
`default_nettype wire

>>> rtl/core/hrhp_classify.sv
`default_nettype none
module hrhp_classify (
    input  wire  hrhp_pkg::t_in_item    i_item,
    output hrhp_pkg::t_byte_class       o_class
);
    import hrhp_pkg::*;

    logic [7:0] w_b;
    logic       w_ctl;
    logic       w_sep;

    assign w_b = i_item.data_byte;

    // Control bytes are the low 32 codes and DEL.
    assign w_ctl = (w_b <= 8'd31) || (w_b == 8'd127);

    // Separator characters of the token grammar.
    always_comb begin
        case (w_b)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
            "/", "[", "]", "?", "=", "{", "}", " ", 8'h09: w_sep = 1'b1;
            default:                                         w_sep = 1'b0;
        endcase
    end

    // Gather every class the parse engine tests.
    always_comb begin
        o_class.data_byte = w_b;
        o_class.restart   = i_item.restart;
        o_class.is_token  = !w_b[7] && !w_ctl && !w_sep;
        o_class.is_ctl    = w_ctl;
        o_class.is_dec    = (w_b >= "0") && (w_b <= "9");
        o_class.is_space  = (w_b == " ");
        o_class.is_tab    = (w_b == 8'h09);
        o_class.is_cr     = (w_b == 8'h0d);
        o_class.is_lf     = (w_b == 8'h0a);
        o_class.is_colon  = (w_b == ":");
        o_class.is_dot    = (w_b == ".");
        o_class.is_slash  = (w_b == "/");
        o_class.is_h      = (w_b == "H");
        o_class.is_t      = (w_b == "T");
        o_class.is_p      = (w_b == "P");
    end

endmodule
`default_nettype wire

>>> rtl/core/hrhp_queue.sv
`default_nettype none
module hrhp_queue (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_push,
    input  wire  hrhp_pkg::t_byte_class i_data,
    output logic                        o_full,
    output logic                        o_valid,
    output hrhp_pkg::t_byte_class       o_data,
    input  wire                         i_pop
);
    import hrhp_pkg::*;

    t_byte_class          r_mem [QueueDepth];
    logic [QueueAw-1:0]   r_wr_ptr;
    logic [QueueAw-1:0]   r_rd_ptr;
    logic [QueueCntW-1:0] r_count;
    logic                 w_push;
    logic                 w_pop;

    assign o_full  = (r_count == QueueCntW'(QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QueueCntW'(QueueDepth))
        else $error("queue count above depth");

    // A pop from a single entry without a push leaves the queue empty.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == QueueCntW'(1) && w_pop && !w_push) |=> !o_valid)
        else $error("queue not empty after last pop");

endmodule
`default_nettype wire

>>> rtl/core/hrhp_engine.sv
`default_nettype none
module hrhp_engine (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    input  wire  hrhp_pkg::t_byte_class i_class,
    output logic                        o_pop,
    output logic                        o_out_valid,
    output hrhp_pkg::t_out_item         o_out_item,
    input  wire                         i_out_stall
);
    import hrhp_pkg::*;

    t_phase      r_phase;
    t_phase      n_phase;
    logic        r_have_header;
    logic        n_have_header;
    logic        r_err;
    logic [7:0]  r_major;
    logic [7:0]  n_major;
    logic [7:0]  r_minor;
    logic [7:0]  n_minor;
    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   n_out;

    t_phase      w_phase;
    logic        w_have_header;
    logic        w_err;
    t_phase      w_next;
    logic        w_bad;
    logic        w_done;
    logic [2:0]  w_tag;
    logic        w_new_header;
    logic [11:0] w_major_acc;
    logic [11:0] w_minor_acc;
    logic [3:0]  w_digit;

    // Take the next byte whenever the output register is free or draining.
    assign o_pop       = i_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Restart applies before the byte it arrives with.
    assign w_phase       = i_class.restart ? PH_METHOD_START : r_phase;
    assign w_have_header = i_class.restart ? 1'b0 : r_have_header;
    assign w_err         = i_class.restart ? 1'b0 : r_err;

    // Decimal accumulate: count * 10 + digit, before saturation.
    assign w_digit     = i_class.data_byte[3:0];
    assign w_major_acc = {1'b0, r_major, 3'b000} + {3'b000, r_major, 1'b0} + {8'h00, w_digit};
    assign w_minor_acc = {1'b0, r_minor, 3'b000} + {3'b000, r_minor, 1'b0} + {8'h00, w_digit};

    // Next phase and the malformed check.
    always_comb begin
        w_next = w_phase;
        w_bad  = 1'b0;
        if (w_err) begin
            w_bad = 1'b1;
        end else begin
            case (w_phase)
                PH_METHOD_START: begin
                    if (i_class.is_token) w_next = PH_METHOD;
                    else                  w_bad  = 1'b1;
                end
                PH_METHOD: begin
                    if (i_class.is_space)      w_next = PH_URI_START;
                    else if (!i_class.is_token) w_bad = 1'b1;
                end
                PH_URI_START: begin
                    if (i_class.is_ctl) w_bad  = 1'b1;
                    else                w_next = PH_URI;
                end
                PH_URI: begin
                    if (i_class.is_space)    w_next = PH_H;
                    else if (i_class.is_ctl) w_bad  = 1'b1;
                end
                PH_H: begin
                    if (i_class.is_h) w_next = PH_T1;
                    else              w_bad  = 1'b1;
                end
                PH_T1: begin
                    if (i_class.is_t) w_next = PH_T2;
                    else              w_bad  = 1'b1;
                end
                PH_T2: begin
                    if (i_class.is_t) w_next = PH_P;
                    else              w_bad  = 1'b1;
                end
                PH_P: begin
                    if (i_class.is_p) w_next = PH_SLASH;
                    else              w_bad  = 1'b1;
                end
                PH_SLASH: begin
                    if (i_class.is_slash) w_next = PH_MAJ_START;
                    else                  w_bad  = 1'b1;
                end
                PH_MAJ_START: begin
                    if (i_class.is_dec) w_next = PH_MAJ;
                    else                w_bad  = 1'b1;
                end
                PH_MAJ: begin
                    if (i_class.is_dot)       w_next = PH_MIN_START;
                    else if (!i_class.is_dec) w_bad  = 1'b1;
                end
                PH_MIN_START: begin
                    if (i_class.is_dec) w_next = PH_MIN;
                    else                w_bad  = 1'b1;
                end
                PH_MIN: begin
                    if (i_class.is_cr)        w_next = PH_LF1;
                    else if (!i_class.is_dec) w_bad  = 1'b1;
                end
                PH_LF1: begin
                    if (i_class.is_lf) w_next = PH_LINE_START;
                    else               w_bad  = 1'b1;
                end
                PH_LINE_START: begin
                    if (i_class.is_cr) begin
                        w_next = PH_LF3;
                    end else if (w_have_header && (i_class.is_space || i_class.is_tab)) begin
                        w_next = PH_LWS;
                    end else if (i_class.is_token) begin
                        w_next = PH_NAME;
                    end else begin
                        w_bad = 1'b1;
                    end
                end
                PH_LWS: begin
                    if (i_class.is_cr) begin
                        w_next = PH_LF2;
                    end else if (i_class.is_space || i_class.is_tab) begin
                        w_next = PH_LWS;
                    end else if (i_class.is_ctl) begin
                        w_bad = 1'b1;
                    end else begin
                        w_next = PH_VALUE;
                    end
                end
                PH_NAME: begin
                    if (i_class.is_colon)       w_next = PH_SP_VALUE;
                    else if (!i_class.is_token) w_bad  = 1'b1;
                end
                PH_SP_VALUE: begin
                    if (i_class.is_space) w_next = PH_VALUE;
                    else                  w_bad  = 1'b1;
                end
                PH_VALUE: begin
                    if (i_class.is_cr)       w_next = PH_LF2;
                    else if (i_class.is_ctl) w_bad  = 1'b1;
                end
                PH_LF2: begin
                    if (i_class.is_lf) w_next = PH_LINE_START;
                    else               w_bad  = 1'b1;
                end
                PH_LF3: begin
                    if (!i_class.is_lf) w_bad = 1'b1;
                end
                default: begin
                    w_bad = 1'b1;
                end
            endcase
        end
    end

    // Field tag, header start, completion and counter updates.
    always_comb begin
        w_tag         = TagNone;
        w_new_header  = 1'b0;
        w_done        = 1'b0;
        n_major       = r_major;
        n_minor       = r_minor;
        n_have_header = w_have_header;
        if (!w_bad) begin
            case (w_phase)
                PH_METHOD_START, PH_METHOD: begin
                    if (i_class.is_token) w_tag = TagMethod;
                end
                PH_URI_START: begin
                    w_tag = TagUri;
                end
                PH_URI: begin
                    if (!i_class.is_space) w_tag = TagUri;
                end
                PH_SLASH: begin
                    n_major = '0;
                    n_minor = '0;
                end
                PH_MAJ_START, PH_MAJ: begin
                    if (i_class.is_dec) begin
                        n_major = (w_major_acc > 12'(VersionMax)) ? VersionMax
                                                                   : w_major_acc[7:0];
                    end
                end
                PH_MIN_START, PH_MIN: begin
                    if (i_class.is_dec) begin
                        n_minor = (w_minor_acc > 12'(VersionMax)) ? VersionMax
                                                                   : w_minor_acc[7:0];
                    end
                end
                PH_LINE_START: begin
                    if (w_next == PH_NAME) begin
                        w_tag         = TagName;
                        w_new_header  = 1'b1;
                        n_have_header = 1'b1;
                    end
                end
                PH_LWS: begin
                    if (w_next == PH_VALUE) w_tag = TagValue;
                end
                PH_NAME: begin
                    if (!i_class.is_colon) w_tag = TagName;
                end
                PH_VALUE: begin
                    if (!i_class.is_cr) w_tag = TagValue;
                end
                PH_LF3: begin
                    w_done = 1'b1;
                end
                default: begin
                    w_tag = TagNone;
                end
            endcase
        end
        n_phase = w_bad ? w_phase : w_next;
    end

    // Assemble the result item.
    always_comb begin
        n_out.status        = w_bad ? StBad : (w_done ? StDone : StMore);
        n_out.field_tag     = w_tag;
        n_out.token_byte    = (w_tag != TagNone) ? i_class.data_byte : 8'h00;
        n_out.new_header    = w_new_header;
        n_out.version_major = n_major;
        n_out.version_minor = n_minor;
        n_out.phase         = n_phase;
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_METHOD_START;
            r_have_header <= 1'b0;
            r_err         <= 1'b0;
            r_major       <= '0;
            r_minor       <= '0;
        end else if (o_pop) begin
            r_phase       <= n_phase;
            r_have_header <= n_have_header;
            r_err         <= w_err || w_bad;
            r_major       <= n_major;
            r_minor       <= n_minor;
        end
    end

    // Output register: loads on every pop, empties when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    // A malformed byte leaves the error latch set.
    a_err_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && n_out.status == StBad) |=> r_err)
        else $error("error latch not set after malformed byte");

    // Without a restart, a latched error answers malformed.
    a_err_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && r_err && !i_class.restart) |-> (n_out.status == StBad))
        else $error("latched error did not answer malformed");

    // A complete head is reported only from the final phase.
    a_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == StDone) |-> (r_out.phase == PH_LF3))
        else $error("complete status outside final phase");

    // No token byte is reported without a field tag.
    a_tag_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.field_tag == TagNone) |-> (r_out.token_byte == 8'h00))
        else $error("token byte without field tag");

endmodule
`default_nettype wire

>>> rtl/core/http_request_head_parser.sv
`default_nettype none
// HTTP request head parser. Bytes of the request stream go in one per item, and every
// byte gives exactly one result item: status (more, complete, malformed), the string
// field the byte belongs to, a new-header flag, the saturating version counters and
// the phase reached. The parser sustains one byte per clock cycle while the output is
// not stalled. The classifier writes each byte into a four-entry queue, and the parse
// engine reads it from the queue, steps its state machine and loads the output
// register. The input is stalled only when the queue is full, and the
// engine stalls only when the output register holds an item that is not taken. After
// a malformed byte every further byte answers malformed until an item with restart
// set arrives; restart does not clear the version counters.
module http_request_head_parser (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    input  wire  hrhp_pkg::t_in_item  i_in_item,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    output hrhp_pkg::t_out_item       o_out_item,
    input  wire                       i_out_stall
);
    import hrhp_pkg::*;

    t_byte_class w_class;
    t_byte_class w_q_data;
    logic        w_q_full;
    logic        w_q_valid;
    logic        w_pop;

    // Front: classify the incoming byte.
    hrhp_classify u_classify (
        .i_item  (i_in_item),
        .o_class (w_class)
    );

    // Queue between classifier and engine.
    hrhp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (w_class),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_pop)
    );

    assign o_in_stall = w_q_full;

    // Back: parse state machine and output register.
    hrhp_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_class     (w_q_data),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule
`default_nettype wire
